>>> hdl/qrs_pkg.sv
package qrs_pkg;

   localparam int COEF_W         = 16;
   localparam int ROOT_W         = 32;
   localparam int ROOT_FRAC_BITS = 16;
   localparam int PROD_W         = 2 * COEF_W;
   localparam int DISC_W         = PROD_W + 3;
   localparam int DMAG_W         = PROD_W + 2;
   localparam int SQRT_STAGES    = DMAG_W / 2 + ROOT_FRAC_BITS;
   localparam int SROOT_W        = SQRT_STAGES;
   localparam int SREM_W         = SROOT_W + 2;
   localparam int NUM_W          = SROOT_W + 3;
   localparam int DEN_W          = COEF_W + 1;
   localparam int DIV_LAT        = NUM_W + 2;
   localparam int LATENCY        = 3 + SQRT_STAGES + 1 + DIV_LAT + 1;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_DEGEN = 2'd1,
      KIND_ONE   = 2'd2,
      KIND_TWO   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                 kind;
      logic [DMAG_W-1:0]        disc;
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
   } job_type;

endpackage

>>> hdl/quadratic_root_solver.sv
// The solver takes one coefficient beat per cycle whenever busy is low and returns one result
// beat, marked by rsp_strobe, for each beat taken, in the order taken; the receiver cannot
// stall, so results must be captured in the cycle they appear. Each beat passes through the two
// stage chains of the back end: a 33-stage square-root pipeline and a divider pipeline per
// root, one quotient bit per stage, behind a registered discriminant front end and a
// two-entry queue. Since the back end drains every cycle, busy stays low in operation.
module quadratic_root_solver (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [qrs_pkg::COEF_W-1:0] req_coef_a,
   input  logic signed [qrs_pkg::COEF_W-1:0] req_coef_b,
   input  logic signed [qrs_pkg::COEF_W-1:0] req_coef_c,
   output logic                              rsp_strobe,
   output logic [1:0]                        rsp_root_count,
   output logic signed [qrs_pkg::ROOT_W-1:0] rsp_root_plus,
   output logic signed [qrs_pkg::ROOT_W-1:0] rsp_root_minus,
   output logic                              rsp_degenerate,
   output logic                              rsp_saturated
);
   import qrs_pkg::*;

   logic               job_valid;
   job_type            job;
   logic               q_valid;
   job_type            q_job;
   logic               q_full;
   logic               s_valid;
   job_type            s_job;
   logic [SROOT_W-1:0] s_root;

   logic                     n_valid_ff;
   kind_type                 n_kind_ff;
   logic signed [COEF_W-1:0] n_a_ff;
   logic signed [NUM_W-1:0]  n_plus_ff;
   logic signed [NUM_W-1:0]  n_minus_ff;
   logic signed [NUM_W-1:0]  base;
   logic signed [NUM_W-1:0]  sroot_ext;

   logic                     m_valid_ff [0:DIV_LAT-1];
   kind_type                 m_kind_ff  [0:DIV_LAT-1];

   logic signed [ROOT_W-1:0] d_plus;
   logic signed [ROOT_W-1:0] d_minus;
   logic                     d_plus_sat;
   logic                     d_minus_sat;

   logic                     strobe_ff;
   logic [1:0]               count_ff;
   logic [1:0]               count_in;
   logic signed [ROOT_W-1:0] plus_ff;
   logic signed [ROOT_W-1:0] plus_in;
   logic signed [ROOT_W-1:0] minus_ff;
   logic signed [ROOT_W-1:0] minus_in;
   logic                     degen_ff;
   logic                     degen_in;
   logic                     sat_ff;
   logic                     sat_in;

   assign busy = q_full;

   qrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (start && !busy),
      .coef_a    (req_coef_a),
      .coef_b    (req_coef_b),
      .coef_c    (req_coef_c),
      .job_valid (job_valid),
      .job       (job)
   );

   qrs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_valid),
      .push_job  (job),
      .pop_valid (q_valid),
      .pop_job   (q_job),
      .full      (q_full)
   );

   qrs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_job    (q_job),
      .out_valid (s_valid),
      .out_job   (s_job),
      .out_root  (s_root)
   );

   assign base      = -($signed({{(NUM_W-COEF_W){s_job.coef_b[COEF_W-1]}}, s_job.coef_b})
                        <<< ROOT_FRAC_BITS);
   assign sroot_ext = $signed({{(NUM_W-SROOT_W){1'b0}}, s_root});

   always_ff @(posedge clock) begin
      if (reset) begin
         n_valid_ff <= 1'b0;
      end else begin
         n_valid_ff <= s_valid;
      end
      n_kind_ff  <= s_job.kind;
      n_a_ff     <= s_job.coef_a;
      n_plus_ff  <= base + sroot_ext;
      n_minus_ff <= base - sroot_ext;
   end

   qrs_div u_div_plus (
      .clock  (clock),
      .numer  (n_plus_ff),
      .coef_a (n_a_ff),
      .root   (d_plus),
      .sat    (d_plus_sat)
   );

   qrs_div u_div_minus (
      .clock  (clock),
      .numer  (n_minus_ff),
      .coef_a (n_a_ff),
      .root   (d_minus),
      .sat    (d_minus_sat)
   );

   for (genvar i = 0; i < DIV_LAT; i++) begin : g_meta
      always_ff @(posedge clock) begin
         if (reset) begin
            m_valid_ff[i] <= 1'b0;
         end else if (i == 0) begin
            m_valid_ff[i] <= n_valid_ff;
         end else begin
            m_valid_ff[i] <= m_valid_ff[(i == 0) ? 0 : i-1];
         end
         if (i == 0) begin
            m_kind_ff[i] <= n_kind_ff;
         end else begin
            m_kind_ff[i] <= m_kind_ff[(i == 0) ? 0 : i-1];
         end
      end
   end

   always_comb begin
      count_in = 2'd0;
      plus_in  = '0;
      minus_in = '0;
      degen_in = 1'b0;
      sat_in   = 1'b0;
      case (m_kind_ff[DIV_LAT-1])
         KIND_NONE: begin
            count_in = 2'd0;
         end
         KIND_DEGEN: begin
            degen_in = 1'b1;
         end
         KIND_ONE: begin
            count_in = 2'd1;
            plus_in  = d_plus;
            minus_in = d_plus;
            sat_in   = d_plus_sat;
         end
         KIND_TWO: begin
            count_in = 2'd2;
            plus_in  = d_plus;
            minus_in = d_minus;
            sat_in   = d_plus_sat || d_minus_sat;
         end
         default: begin
            count_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= m_valid_ff[DIV_LAT-1];
      end
      count_ff <= count_in;
      plus_ff  <= plus_in;
      minus_ff <= minus_in;
      degen_ff <= degen_in;
      sat_ff   <= sat_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_root_count = count_ff;
   assign rsp_root_plus  = plus_ff;
   assign rsp_root_minus = minus_ff;
   assign rsp_degenerate = degen_ff;
   assign rsp_saturated  = sat_ff;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("The queue filled although the back end drains every cycle.");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("A result beat did not appear at the fixed latency.");

   a_degen: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_degenerate) |-> (rsp_root_count == 2'd0 && !rsp_saturated))
      else $error("A degenerate result reported roots.");

   a_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_root_count == 2'd1) |-> (rsp_root_plus == rsp_root_minus))
      else $error("A single root differs between the two root fields.");

endmodule

>>> hdl/qrs_front.sv
module qrs_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             take,
   input  logic signed [qrs_pkg::COEF_W-1:0] coef_a,
   input  logic signed [qrs_pkg::COEF_W-1:0] coef_b,
   input  logic signed [qrs_pkg::COEF_W-1:0] coef_c,
   output logic                             job_valid,
   output qrs_pkg::job_type                 job
);
   import qrs_pkg::*;

   logic                     v1_ff;
   logic signed [COEF_W-1:0] a1_ff;
   logic signed [COEF_W-1:0] b1_ff;
   logic signed [PROD_W-1:0] bb_ff;
   logic signed [PROD_W-1:0] ac_ff;
   logic signed [DISC_W-1:0] disc;
   logic                     jv_ff;
   job_type                  job_ff;
   job_type                  job_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         jv_ff <= 1'b0;
      end else begin
         v1_ff <= take;
         jv_ff <= v1_ff;
      end
      a1_ff  <= coef_a;
      b1_ff  <= coef_b;
      bb_ff  <= coef_b * coef_b;
      ac_ff  <= coef_a * coef_c;
      job_ff <= job_in;
   end

   always_comb begin
      disc = $signed({{(DISC_W-PROD_W){bb_ff[PROD_W-1]}}, bb_ff})
           - $signed({{(DISC_W-PROD_W-2){ac_ff[PROD_W-1]}}, ac_ff, 2'b00});
      job_in.disc   = disc[DMAG_W-1:0];
      job_in.coef_a = a1_ff;
      job_in.coef_b = b1_ff;
      if (a1_ff == '0) begin
         job_in.kind = KIND_DEGEN;
      end else if (disc[DISC_W-1]) begin
         job_in.kind = KIND_NONE;
      end else if (disc == '0) begin
         job_in.kind = KIND_ONE;
      end else begin
         job_in.kind = KIND_TWO;
      end
   end

   assign job_valid = jv_ff;
   assign job       = job_ff;

endmodule

>>> hdl/qrs_fifo.sv
module qrs_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  qrs_pkg::job_type push_job,
   output logic             pop_valid,
   output qrs_pkg::job_type pop_job,
   output logic             full
);
   import qrs_pkg::*;

   job_type    mem_ff [0:1];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push;
   logic       do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_job   = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> hdl/qrs_sqrt.sv
module qrs_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  qrs_pkg::job_type              in_job,
   output logic                          out_valid,
   output qrs_pkg::job_type              out_job,
   output logic [qrs_pkg::SROOT_W-1:0]   out_root
);
   import qrs_pkg::*;

   logic               v_ff    [0:SQRT_STAGES-1];
   job_type            job_ff  [0:SQRT_STAGES-1];
   logic [DMAG_W-1:0]  rad_ff  [0:SQRT_STAGES-1];
   logic [SREM_W-1:0]  rem_ff  [0:SQRT_STAGES-1];
   logic [SROOT_W-1:0] root_ff [0:SQRT_STAGES-1];

   for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
      logic               pv;
      job_type            pjob;
      logic [DMAG_W-1:0]  prad;
      logic [SREM_W-1:0]  prem;
      logic [SROOT_W-1:0] proot;
      logic [SREM_W-1:0]  rem_cat;
      logic [SREM_W-1:0]  trial;
      logic               ge;

      if (i == 0) begin : g_first
         assign pv    = in_valid;
         assign pjob  = in_job;
         assign prad  = in_job.disc;
         assign prem  = '0;
         assign proot = '0;
      end else begin : g_next
         assign pv    = v_ff[i-1];
         assign pjob  = job_ff[i-1];
         assign prad  = rad_ff[i-1];
         assign prem  = rem_ff[i-1];
         assign proot = root_ff[i-1];
      end

      assign rem_cat = {prem[SREM_W-3:0], prad[DMAG_W-1 -: 2]};
      assign trial   = {proot, 2'b01};
      assign ge      = (rem_cat >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else begin
            v_ff[i] <= pv;
         end
         job_ff[i]  <= pjob;
         rad_ff[i]  <= {prad[DMAG_W-3:0], 2'b00};
         rem_ff[i]  <= ge ? (rem_cat - trial) : rem_cat;
         root_ff[i] <= {proot[SROOT_W-2:0], ge};
      end
   end

   assign out_valid = v_ff[SQRT_STAGES-1];
   assign out_job   = job_ff[SQRT_STAGES-1];
   assign out_root  = root_ff[SQRT_STAGES-1];

endmodule

>>> hdl/qrs_div.sv
module qrs_div (
   input  logic                               clock,
   input  logic signed [qrs_pkg::NUM_W-1:0]   numer,
   input  logic signed [qrs_pkg::COEF_W-1:0]  coef_a,
   output logic signed [qrs_pkg::ROOT_W-1:0]  root,
   output logic                               sat
);
   import qrs_pkg::*;

   localparam logic [NUM_W-1:0] MAX_MAG = NUM_W'((64'd1 << (ROOT_W - 1)) - 64'd1);
   localparam logic [NUM_W-1:0] MIN_MAG = NUM_W'(64'd1 << (ROOT_W - 1));

   logic [NUM_W-1:0]  nmag;
   logic [COEF_W-1:0] amag;
   logic [NUM_W-1:0]  num0_ff;
   logic [DEN_W-1:0]  den0_ff;
   logic              neg0_ff;
   logic [NUM_W-1:0]  num_ff [0:NUM_W-1];
   logic [DEN_W-1:0]  den_ff [0:NUM_W-1];
   logic [DEN_W-1:0]  rem_ff [0:NUM_W-1];
   logic              neg_ff [0:NUM_W-1];
   logic [NUM_W-1:0]  q;
   logic              qneg;
   logic signed [ROOT_W-1:0] root_in;
   logic              sat_in;
   logic signed [ROOT_W-1:0] root_ff;
   logic              sat_ff;

   assign nmag = numer[NUM_W-1] ? NUM_W'(-numer) : NUM_W'(numer);
   assign amag = coef_a[COEF_W-1] ? COEF_W'(-coef_a) : COEF_W'(coef_a);

   always_ff @(posedge clock) begin
      num0_ff <= nmag + {{(NUM_W-COEF_W){1'b0}}, amag};
      den0_ff <= {amag, 1'b0};
      neg0_ff <= numer[NUM_W-1] ^ coef_a[COEF_W-1];
   end

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic [NUM_W-1:0] pnum;
      logic [DEN_W-1:0] pden;
      logic [DEN_W-1:0] prem;
      logic             pneg;
      logic [DEN_W:0]   rem_cat;
      logic [DEN_W:0]   diff;
      logic             ge;

      if (i == 0) begin : g_first
         assign pnum = num0_ff;
         assign pden = den0_ff;
         assign prem = '0;
         assign pneg = neg0_ff;
      end else begin : g_next
         assign pnum = num_ff[i-1];
         assign pden = den_ff[i-1];
         assign prem = rem_ff[i-1];
         assign pneg = neg_ff[i-1];
      end

      assign rem_cat = {prem, pnum[NUM_W-1]};
      assign ge      = (rem_cat >= {1'b0, pden});
      assign diff    = rem_cat - {1'b0, pden};

      always_ff @(posedge clock) begin
         num_ff[i] <= {pnum[NUM_W-2:0], ge};
         den_ff[i] <= pden;
         rem_ff[i] <= ge ? diff[DEN_W-1:0] : rem_cat[DEN_W-1:0];
         neg_ff[i] <= pneg;
      end
   end

   assign q    = num_ff[NUM_W-1];
   assign qneg = neg_ff[NUM_W-1];

   always_comb begin
      sat_in  = 1'b0;
      root_in = '0;
      if (q == '0) begin
         root_in = '0;
      end else if (qneg) begin
         if (q > MIN_MAG) begin
            sat_in  = 1'b1;
            root_in = $signed(ROOT_W'(-MIN_MAG));
         end else begin
            root_in = $signed(ROOT_W'(-q));
         end
      end else begin
         if (q > MAX_MAG) begin
            sat_in  = 1'b1;
            root_in = $signed(ROOT_W'(MAX_MAG));
         end else begin
            root_in = $signed(q[ROOT_W-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      root_ff <= root_in;
      sat_ff  <= sat_in;
   end

   assign root = root_ff;
   assign sat  = sat_ff;

endmodule

>>> bench/quadratic_root_solver_tb.sv
module quadratic_root_solver_tb;
   import qrs_pkg::*;

   typedef struct {
      logic [1:0]  root_count;
      logic [31:0] root_plus;
      logic [31:0] root_minus;
      logic        degenerate;
      logic        saturated;
   } roots_type;

   localparam int TAIL_CYCLES = 76 + 20;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic signed [COEF_W-1:0] req_coef_a = '0;
   logic signed [COEF_W-1:0] req_coef_b = '0;
   logic signed [COEF_W-1:0] req_coef_c = '0;
   logic                     rsp_strobe;
   logic [1:0]               rsp_root_count;
   logic signed [ROOT_W-1:0] rsp_root_plus;
   logic signed [ROOT_W-1:0] rsp_root_minus;
   logic                     rsp_degenerate;
   logic                     rsp_saturated;

   roots_type expected_roots[$];
   int        error_count = 0;
   int        burst_left = 0;

   quadratic_root_solver i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_coef_a     (req_coef_a),
      .req_coef_b     (req_coef_b),
      .req_coef_c     (req_coef_c),
      .rsp_strobe     (rsp_strobe),
      .rsp_root_count (rsp_root_count),
      .rsp_root_plus  (rsp_root_plus),
      .rsp_root_minus (rsp_root_minus),
      .rsp_degenerate (rsp_degenerate),
      .rsp_saturated  (rsp_saturated)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [63:0] isqrt_scaled(logic [63:0] d);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] trial;
      logic [63:0] pair;
      rem = 0;
      root = 0;
      for (int i = 0; i < 17 + ROOT_FRAC_BITS; i++) begin
         pair = (i < 17) ? ((d >> (2 * (16 - i))) & 64'd3) : 64'd0;
         rem = (rem << 2) | pair;
         trial = (root << 2) | 64'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 64'd1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic logic [31:0] round_divide(longint n, longint a, ref logic sat);
      logic        neg;
      logic [63:0] nm;
      logic [63:0] am;
      logic [63:0] q;
      neg = (n < 0) != (a < 0);
      nm = (n < 0) ? -n : n;
      am = (a < 0) ? -a : a;
      q = (nm + am) / (2 * am);
      if (q == 0) return 32'd0;
      if (neg) begin
         if (q > 64'd2147483648) begin
            sat = 1'b1;
            q = 64'd2147483648;
         end
         return 32'(-q);
      end
      if (q > 64'd2147483647) begin
         sat = 1'b1;
         q = 64'd2147483647;
      end
      return q[31:0];
   endfunction

   function automatic roots_type solve_roots(logic signed [15:0] ca, logic signed [15:0] cb,
                                             logic signed [15:0] cc);
      roots_type r;
      longint    a;
      longint    b;
      longint    c;
      longint    d;
      longint    base;
      longint    s;
      logic      sat;
      a = ca;
      b = cb;
      c = cc;
      sat = 1'b0;
      r = '{2'd0, 32'd0, 32'd0, 1'b0, 1'b0};
      if (a == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      d = b * b - 4 * a * c;
      if (d < 0) return r;
      base = -b * (longint'(1) << ROOT_FRAC_BITS);
      if (d == 0) begin
         r.root_count = 2'd1;
         r.root_plus = round_divide(base, a, sat);
         r.root_minus = r.root_plus;
      end else begin
         s = longint'(isqrt_scaled(d));
         r.root_count = 2'd2;
         r.root_plus = round_divide(base + s, a, sat);
         r.root_minus = round_divide(base - s, a, sat);
      end
      r.saturated = sat;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   always @(posedge clock) begin
      roots_type w;
      if (!reset && rsp_strobe) begin
         if (expected_roots.size() == 0) begin
            report_mismatch("unexpected beat", 32'd0, 32'd0);
         end else begin
            w = expected_roots.pop_front();
            if (rsp_root_count !== w.root_count)
               report_mismatch("root_count", rsp_root_count, w.root_count);
            if (rsp_root_plus !== w.root_plus)
               report_mismatch("root_plus", rsp_root_plus, w.root_plus);
            if (rsp_root_minus !== w.root_minus)
               report_mismatch("root_minus", rsp_root_minus, w.root_minus);
            if (rsp_degenerate !== w.degenerate)
               report_mismatch("degenerate", rsp_degenerate, w.degenerate);
            if (rsp_saturated !== w.saturated)
               report_mismatch("saturated", rsp_saturated, w.saturated);
         end
      end
   end

   task automatic send_coefs(logic signed [15:0] a, logic signed [15:0] b,
                             logic signed [15:0] c);
      int gap;
      start <= 1'b1;
      req_coef_a <= a;
      req_coef_b <= b;
      req_coef_c <= c;
      @(posedge clock iff !busy);
      expected_roots.push_back(solve_roots(a, b, c));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(0, 4);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(0, 20);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (expected_roots.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_coefs(16'sd0, 16'sd5, 16'sd7);
      send_coefs(16'sd256, 16'sd0, 16'sd256);
      send_coefs(16'sd256, -16'sd512, 16'sd256);
      send_coefs(16'sd256, 16'sd0, -16'sd1024);
      send_coefs(16'sd1, 16'sd0, 16'sd0);
      send_coefs(16'sd1, -16'sd32768, 16'sd0);
      send_coefs(16'sd1, 16'sd32767, -16'sd32768);
      send_coefs(-16'sd32768, -16'sd32768, 16'sd32767);
      send_coefs(16'sd32767, 16'sd32767, -16'sd32768);
      send_coefs(-16'sd32768, 16'sd32767, 16'sd32767);
      send_coefs(-16'sd1, 16'sd32767, 16'sd32767);
      send_coefs(-16'sd32768, 16'sd0, 16'sd0);
      send_coefs(16'sd32767, -16'sd32768, -16'sd32768);
      send_coefs(-16'sd1, -16'sd1, -16'sd1);
      send_coefs(16'sd3, 16'sd6, 16'sd3);
      send_coefs(-16'sd2, 16'sd4, -16'sd2);
      send_coefs(16'sd1, 16'sd1, 16'sd0);
      send_coefs(16'sd0, 16'sd0, 16'sd0);
   endtask

   task automatic test_random();
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic signed [15:0] c;
      logic signed [15:0] r;
      for (int n = 0; n < 2000; n++) begin
         a = 16'($urandom());
         b = 16'($urandom());
         c = 16'($urandom());
         case ($urandom_range(0, 5))
            0: begin
               a = $signed(16'($urandom_range(0, 15))) - 16'sd8;
               c = $signed(16'($urandom_range(0, 31))) - 16'sd16;
            end
            1: begin
               r = $signed(16'($urandom_range(0, 31))) - 16'sd16;
               a = $signed(16'($urandom_range(1, 64)));
               b = 16'(-2 * a * r);
               c = 16'(a * r * r);
            end
            2: a = 16'sd0;
            default: ;
         endcase
         send_coefs(a, b, c);
         if (n == 1000) wait_drained();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_drained();
      test_random();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("quadratic_root_solver_tb: done, clean");
      else
         $display("quadratic_root_solver_tb: done, errors");
      $finish;
   end

   initial begin
      #2000000;
      $display("quadratic_root_solver_tb: done, errors");
      $finish;
   end

endmodule

>>> filelist.f
hdl/qrs_pkg.sv
hdl/qrs_front.sv
hdl/qrs_fifo.sv
hdl/qrs_sqrt.sv
hdl/qrs_div.sv
hdl/quadratic_root_solver.sv
bench/quadratic_root_solver_tb.sv
